// ===== rtl/rssp_pkg.sv =====
// Shared types, constants and the duty lookup of the reversing soft-start PWM sequencer.
package rssp_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] RAMP_STEP_RESET = 16'd500;
    localparam logic [COUNT_W-1:0] RUN_RESET       = 16'd5000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

    localparam logic [LEVEL_W-1:0] START_LEVEL = 4'd2;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 4'd8;
    localparam logic [DUTY_W-1:0]  FULL_DUTY   = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN       = 1'd1;

    // Step within one direction; the top phase bit selects the direction.
    localparam logic [1:0] STEP_START = 2'd0;
    localparam logic [1:0] STEP_UP    = 2'd1;
    localparam logic [1:0] STEP_RUN   = 2'd2;
    localparam logic [1:0] STEP_DOWN  = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] ramp_step_ms;
        logic [COUNT_W-1:0] run_ms;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_forward;
        logic [DUTY_W-1:0]  duty_reverse;
        logic [PHASE_W-1:0] phase;
    } result_t;

    // Duty for a ramp level: 32 * level - 1, limited to full duty, and zero at level zero.
    function automatic logic [DUTY_W-1:0] level_duty(input logic [LEVEL_W-1:0] level);
        logic [DUTY_W-1:0] d;
        if (level == '0)
        begin
            d = '0;
        end
        else if (level >= TOP_LEVEL)
        begin
            d = FULL_DUTY;
        end
        else
        begin
            d = {level[2:0] - 3'd1, 5'b11111};
        end
        return d;
    endfunction

endpackage

// ===== rtl/rssp_in_if.sv =====
// Input channel: one tick word per handshake.
interface rssp_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ===== rtl/rssp_out_if.sv =====
// Output channel: duties and phase after each evaluation.
interface rssp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty_forward;
    logic [7:0] duty_reverse;
    logic [2:0] phase;

    modport source (output valid, output duty_forward, output duty_reverse, output phase,
                    input ready);
    modport sink (input valid, input duty_forward, input duty_reverse, input phase,
                  output ready);
endinterface

// ===== rtl/rssp_cfg.sv =====
// Configuration registers: ramp step and full-duty run times.
module rssp_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rssp_pkg::COUNT_W-1:0]   cfg_wdata,
    output rssp_pkg::cfg_t                 cfg
);
    import rssp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP_STEP: cfg_next.ramp_step_ms = cfg_wdata;
                REG_RUN:       cfg_next.run_ms       = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_step_ms <= RAMP_STEP_RESET;
            cfg_reg.run_ms       <= RUN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rssp_core.sv =====
// Sequencer state and its single-pass update for one accepted word.
module rssp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              tick,
    input  rssp_pkg::cfg_t    cfg,
    output rssp_pkg::result_t state
);
    import rssp_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [COUNT_W-1:0] ramp_reg, ramp_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [DUTY_W-1:0]  fwd_reg, fwd_next;
    logic [DUTY_W-1:0]  rev_reg, rev_next;

    logic [COUNT_W-1:0] ramp_cnt;
    logic [COUNT_W-1:0] run_cnt;
    logic [LEVEL_W-1:0] level_tmp;
    logic [DUTY_W-1:0]  duty_val;
    logic [PHASE_W-1:0] phase_inc;

    always_comb
    begin
        // Elapsed counters saturate, so a limit of all ones is never exceeded.
        ramp_cnt = (tick && ramp_reg != COUNT_MAX) ? ramp_reg + 16'd1 : ramp_reg;
        run_cnt  = (tick && run_reg != COUNT_MAX) ? run_reg + 16'd1 : run_reg;
        phase_inc = phase_reg + 3'd1;

        phase_next = phase_reg;
        level_next = level_reg;
        ramp_next  = ramp_cnt;
        run_next   = run_cnt;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;
        level_tmp  = level_reg;
        duty_val   = '0;

        unique case (phase_reg[1:0])
            STEP_START:
            begin
                run_next   = '0;
                ramp_next  = '0;
                level_next = START_LEVEL;
                phase_next = phase_inc;
            end
            STEP_UP:
            begin
                if (ramp_cnt > cfg.ramp_step_ms)
                begin
                    ramp_next = '0;
                    level_tmp = level_reg + 4'd1;
                end
                duty_val   = level_duty(level_tmp);
                level_next = level_tmp;
                if (level_tmp >= TOP_LEVEL)
                begin
                    duty_val   = FULL_DUTY;
                    level_next = '0;
                    run_next   = '0;
                    phase_next = phase_inc;
                end
            end
            STEP_RUN:
            begin
                if (run_cnt > cfg.run_ms)
                begin
                    run_next   = '0;
                    ramp_next  = '0;
                    level_next = TOP_LEVEL;
                    phase_next = phase_inc;
                end
            end
            STEP_DOWN:
            begin
                if (ramp_cnt > cfg.ramp_step_ms)
                begin
                    ramp_next = '0;
                    level_tmp = level_reg - 4'd1;
                end
                duty_val   = level_duty(level_tmp);
                level_next = level_tmp;
                if (level_tmp < START_LEVEL)
                begin
                    duty_val   = '0;
                    level_next = '0;
                    run_next   = '0;
                    phase_next = phase_inc;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Ramping steps drive the duty of the active direction only.
        if (phase_reg[1:0] == STEP_UP || phase_reg[1:0] == STEP_DOWN)
        begin
            if (phase_reg[2])
            begin
                rev_next = duty_val;
            end
            else
            begin
                fwd_next = duty_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            level_reg <= '0;
            ramp_reg  <= '0;
            run_reg   <= '0;
            fwd_reg   <= '0;
            rev_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            ramp_reg  <= ramp_next;
            run_reg   <= run_next;
            fwd_reg   <= fwd_next;
            rev_reg   <= rev_next;
        end
    end

    assign state.duty_forward = fwd_reg;
    assign state.duty_reverse = rev_reg;
    assign state.phase        = phase_reg;

endmodule

// ===== rtl/reversing_soft_start_pwm_sequencer.sv =====
// Latency: the result word for an input word is valid in the cycle after it is accepted.
// Throughput: one word per cycle; the state registers double as the output register and
// advance only when the previous result is taken, or in the same cycle as it is taken.
// Reset: asynchronous and active low; the sequencer restarts at phase 0 with both duties
// at zero, ramp step 500 ms and run time 5000 ms, and no result is pending.
module reversing_soft_start_pwm_sequencer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rssp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rssp_pkg::COUNT_W-1:0]   cfg_wdata,
    rssp_in_if.sink                        in_ch,
    rssp_out_if.source                     out_ch
);
    import rssp_pkg::*;

    cfg_t    cfg;
    result_t state;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    accept;

    // A new word may enter when no result is pending or the pending result leaves in the same cycle.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    rssp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rssp_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .tick    (in_ch.tick),
        .cfg     (cfg),
        .state   (state)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.duty_forward = state.duty_forward;
    assign out_ch.duty_reverse = state.duty_reverse;
    assign out_ch.phase        = state.phase;

endmodule

// ===== rtl/rssp_chk.sv =====
// Port-level checks of the sequencer and their attachment to the top level.
module rssp_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] duty_forward,
    input logic [7:0] duty_reverse,
    input logic [2:0] phase
);

    // A result word stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn before it was taken");

    // Every accepted word yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // With nothing pending the block must take input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while no result is pending");

    // One evaluation moves the phase by at most one step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=>
            (phase == $past(phase)) || (phase == 3'($past(phase) + 3'd1)))
        else $error("phase skipped a step");

    // The two drive directions never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        duty_forward == 8'd0 || duty_reverse == 8'd0)
        else $error("forward and reverse drives both active");

endmodule

bind reversing_soft_start_pwm_sequencer rssp_chk u_rssp_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .duty_forward (out_ch.duty_forward),
    .duty_reverse (out_ch.duty_reverse),
    .phase        (out_ch.phase)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the reversing soft-start PWM sequencer.
module testbench;
    import rssp_pkg::*;

    localparam int unsigned HALF_PERIOD     = 2;
    localparam int unsigned IDLE_PCT        = 29;
    localparam int unsigned TICK_PCT        = 75;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned WORDS_PER_PHASE = 210;
    localparam int unsigned SCRIPT_ROWS     = 20;
    localparam int unsigned MAX_PRINTED     = 100;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [COUNT_W-1:0]   value;
        logic                 tick;
        logic [16:0]          repeats;
        logic                 typed;
        result_t              want;
    } script_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_wdata;

    rssp_in_if  in_ch();
    rssp_out_if out_ch();

    reversing_soft_start_pwm_sequencer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Own copy of the drum state and its two timing registers.
    logic [PHASE_W-1:0] drum_phase;
    logic [LEVEL_W-1:0] drum_level;
    logic [COUNT_W-1:0] ramp_ms_seen;
    logic [COUNT_W-1:0] run_ms_seen;
    logic [DUTY_W-1:0]  fwd_duty;
    logic [DUTY_W-1:0]  rev_duty;
    logic [COUNT_W-1:0] ramp_step_limit;
    logic [COUNT_W-1:0] run_limit;

    result_t     pending_results[$];
    int unsigned err_count;
    int unsigned words_taken;
    int unsigned results_checked;
    int unsigned reg_writes;
    int unsigned reversals;
    int unsigned quiet_cycles;
    bit          hold_request;
    bit          steady;
    logic        next_typed;
    result_t     next_want;

    function automatic logic [DUTY_W-1:0] duty_for_level(input logic [LEVEL_W-1:0] level);
        int unsigned d;
        if (level == '0)
        begin
            return '0;
        end
        d = 32 * level - 1;
        return (d > FULL_DUTY) ? FULL_DUTY : d[DUTY_W-1:0];
    endfunction

    function automatic void reset_drum();
        drum_phase      = '0;
        drum_level      = '0;
        ramp_ms_seen    = '0;
        run_ms_seen     = '0;
        fwd_duty        = '0;
        rev_duty        = '0;
        ramp_step_limit = RAMP_STEP_RESET;
        run_limit       = RUN_RESET;
    endfunction

    // One evaluation of the drum sequence; returns the duties and phase that follow it.
    function automatic result_t advance_drum(input logic tick);
        logic [DUTY_W-1:0]  duty;
        logic [PHASE_W-1:0] was;
        result_t            r;
        was  = drum_phase;
        duty = was[2] ? rev_duty : fwd_duty;
        if (tick)
        begin
            if (ramp_ms_seen != COUNT_MAX)
            begin
                ramp_ms_seen = ramp_ms_seen + 1'b1;
            end
            if (run_ms_seen != COUNT_MAX)
            begin
                run_ms_seen = run_ms_seen + 1'b1;
            end
        end
        case (was[1:0])
            STEP_START:
            begin
                run_ms_seen  = '0;
                ramp_ms_seen = '0;
                drum_level   = START_LEVEL;
                drum_phase   = drum_phase + 1'b1;
            end
            STEP_UP:
            begin
                if (ramp_ms_seen > ramp_step_limit)
                begin
                    ramp_ms_seen = '0;
                    drum_level   = drum_level + 1'b1;
                end
                duty = duty_for_level(drum_level);
                if (drum_level >= TOP_LEVEL)
                begin
                    duty        = FULL_DUTY;
                    drum_level  = '0;
                    run_ms_seen = '0;
                    drum_phase  = drum_phase + 1'b1;
                end
            end
            STEP_RUN:
            begin
                if (run_ms_seen > run_limit)
                begin
                    run_ms_seen  = '0;
                    ramp_ms_seen = '0;
                    drum_level   = TOP_LEVEL;
                    drum_phase   = drum_phase + 1'b1;
                end
            end
            default:
            begin
                if (ramp_ms_seen > ramp_step_limit)
                begin
                    ramp_ms_seen = '0;
                    drum_level   = drum_level - 1'b1;
                end
                duty = duty_for_level(drum_level);
                if (drum_level < START_LEVEL)
                begin
                    duty        = '0;
                    drum_level  = '0;
                    run_ms_seen = '0;
                    drum_phase  = drum_phase + 1'b1;
                    reversals++;
                end
            end
        endcase
        if (was[2])
        begin
            rev_duty = duty;
        end
        else
        begin
            fwd_duty = duty;
        end
        r.duty_forward = fwd_duty;
        r.duty_reverse = rev_duty;
        r.phase        = drum_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= MAX_PRINTED)
        begin
            $display("[%0t ns] %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Offers one tick word after a random gap, none while steady, and returns at the falling edge after it is taken.
    task automatic send_word(input logic tick, input logic typed, input result_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.tick  <= tick;
        next_typed = typed;
        next_want  = want;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Registers are only written once the block has handed over every pending result.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COUNT_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                moved = 1'b1;
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result word with nothing pending, phase", out_ch.phase, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.duty_forward !== want.duty_forward)
                    begin
                        report_mismatch("duty_forward", out_ch.duty_forward, want.duty_forward);
                    end
                    if (out_ch.duty_reverse !== want.duty_reverse)
                    begin
                        report_mismatch("duty_reverse", out_ch.duty_reverse, want.duty_reverse);
                    end
                    if (out_ch.phase !== want.phase)
                    begin
                        report_mismatch("phase", out_ch.phase, want.phase);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                moved = 1'b1;
                words_taken++;
                want = advance_drum(in_ch.tick);
                if (next_typed)
                begin
                    want = next_want;
                end
                pending_results.push_back(want);
            end
            if (cfg_we)
            begin
                moved = 1'b1;
                reg_writes++;
                if (cfg_index == REG_RAMP_STEP)
                begin
                    ramp_step_limit = cfg_wdata;
                end
                else if (cfg_index == REG_RUN)
                begin
                    run_limit = cfg_wdata;
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timed out after %0d cycles without a handshake", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int unsigned held;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held != 0)
            begin
                held--;
                out_ch.ready <= 1'b0;
            end
            else if (steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin : stimulus
        script_row_t        script [SCRIPT_ROWS];
        int unsigned        n;
        int unsigned        p;
        int unsigned        k;
        logic [COUNT_W-1:0] ramp_pick;
        logic [COUNT_W-1:0] run_pick;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_RAMP_STEP;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.tick   = 1'b0;
        out_ch.ready = 1'b0;
        err_count       = 0;
        words_taken     = 0;
        results_checked = 0;
        reg_writes      = 0;
        reversals       = 0;
        quiet_cycles    = 0;
        hold_request    = 1'b0;
        steady          = 1'b0;
        next_typed      = 1'b0;
        next_want       = '0;
        reset_drum();

        script = '{
            // An untimed word straight after reset still leaves the start phase.
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd0,   8'd0,   3'd1}},
            '{ROW_CFG,  REG_RAMP_STEP, 16'd0,     1'b0, 17'd0,     1'b0, '0},
            '{ROW_CFG,  REG_RUN,       16'd0,     1'b0, 17'd0,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd63,  8'd0,   3'd1}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd6,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd255, 8'd0,   3'd2}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd1,     1'b1, '{8'd255, 8'd0,   3'd3}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd6,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd1,     1'b1, '{8'd0,   8'd0,   3'd4}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd0,   8'd0,   3'd5}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd0,   8'd63,  3'd5}},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd6,     1'b0, '0},
            // A full-scale run time keeps the drum at full duty.
            '{ROW_CFG,  REG_RUN,       16'hFFFF,  1'b0, 17'd0,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd40,    1'b1, '{8'd0,   8'd255, 3'd6}},
            '{ROW_CFG,  REG_RUN,       16'd20,    1'b0, 17'd0,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b0, 17'd1,     1'b1, '{8'd0,   8'd255, 3'd7}},
            '{ROW_CFG,  REG_RAMP_STEP, 16'hFFFF,  1'b0, 17'd0,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd300,   1'b1, '{8'd0,   8'd255, 3'd7}},
            '{ROW_CFG,  REG_RAMP_STEP, 16'd1,     1'b0, 17'd0,     1'b0, '0},
            '{ROW_WORD, REG_RAMP_STEP, 16'd0,     1'b1, 17'd30,    1'b0, '0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                write_reg(script[i].index, script[i].value);
            end
            else
            begin
                for (n = 0; n < script[i].repeats; n++)
                begin
                    send_word(script[i].tick, script[i].typed, script[i].want);
                end
            end
        end

        // Short timings keep the random words cycling through every phase many times.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    ramp_pick = '0;
                    run_pick  = '0;
                end
                1:
                begin
                    ramp_pick = 16'($urandom_range(0, 3));
                    run_pick  = 16'($urandom_range(0, 12));
                end
                2:
                begin
                    ramp_pick = 16'($urandom_range(1, 6));
                    run_pick  = 16'($urandom_range(5, 40));
                end
                3:
                begin
                    ramp_pick = '0;
                    run_pick  = 16'($urandom_range(0, 4));
                end
                4:
                begin
                    ramp_pick = 16'($urandom_range(2, 8));
                    run_pick  = 16'($urandom_range(0, 2));
                end
                default:
                begin
                    ramp_pick = 16'($urandom_range(0, 2));
                    run_pick  = 16'($urandom_range(0, 20));
                end
            endcase
            write_reg(REG_RAMP_STEP, ramp_pick);
            write_reg(REG_RUN, run_pick);
            steady = (p == 2);
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (p == 3 && k == 100)
                begin
                    hold_request = 1'b1;
                end
                send_word($urandom_range(0, 99) < TICK_PCT, 1'b0, '0);
            end
            steady = 1'b0;
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);

        $display("Drove %0d tick words through %0d register writes and %0d changes of direction,",
                 words_taken, reg_writes, reversals);
        $display("including a full-scale run time and a long output stall; %0d result words checked.",
                 results_checked);
        if (err_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
